// ----- rtl/core/line_pair_intersection_top_macros.svh -----
// Assertion macros used by the line pair intersection checker.
`ifndef LINE_PAIR_INTERSECTION_TOP_MACROS_SVH
`define LINE_PAIR_INTERSECTION_TOP_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define LPI_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line pair intersection check failed");

// Next-cycle implication, disabled while rst is high.
`define LPI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line pair intersection check failed");

`endif

// ----- rtl/core/lpi_pkg.sv -----
// Shared widths, types and helpers of the line pair intersection block.
package lpi_pkg;

   localparam int COORD_BITS = 14;
   localparam int DIFF_W     = COORD_BITS + 1;
   localparam int CROSS_W    = 2 * COORD_BITS;
   localparam int PDEN_W     = 2 * DIFF_W;
   localparam int DEN_W      = PDEN_W + 1;
   localparam int PNUM_W     = CROSS_W + DIFF_W;
   localparam int NUM_W      = PNUM_W + 1;
   localparam int OUT_W      = 43;
   localparam int REG_W      = 14;
   localparam int IN_W       = 8 * COORD_BITS;
   localparam int IN_BYTES_W = ((IN_W + 7) / 8) * 8;
   localparam int OUT_RAW_W  = 2 * OUT_W + 2;
   localparam int OUT_BYTES_W = ((OUT_RAW_W + 7) / 8) * 8;
   localparam int ROWS_RESET = 480;
   localparam int COLS_RESET = 640;

   typedef enum logic [1:0] {
      STATUS_INSIDE   = 2'd0,
      STATUS_PARALLEL = 2'd1,
      STATUS_OUTSIDE  = 2'd2
   } status_type;

   typedef enum logic {
      REG_IMAGE_ROWS = 1'b0,
      REG_IMAGE_COLS = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic              valid;
      logic              neg_x;
      logic              neg_y;
      logic              den_zero;
      logic [NUM_W-1:0]  num_x;
      logic [NUM_W-1:0]  num_y;
      logic [DEN_W-1:0]  den;
   } front_out_type;

   typedef struct packed {
      logic              valid;
      logic              neg_x;
      logic              neg_y;
      logic              den_zero;
      logic [NUM_W-1:0]  quo_x;
      logic [NUM_W-1:0]  quo_y;
   } div_out_type;

   typedef struct packed {
      logic [DEN_W-1:0]  rem;
      logic [NUM_W-1:0]  quo;
   } lane_type;

   // One restoring division step: brings in the next dividend bit.
   function automatic lane_type div_step(lane_type lane, logic [DEN_W-1:0] d);
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      lane_type       res;
      trial = {lane.rem, lane.quo[NUM_W-1]};
      diff  = trial - {1'b0, d};
      if (trial >= {1'b0, d}) begin
         res.rem = diff[DEN_W-1:0];
         res.quo = {lane.quo[NUM_W-2:0], 1'b1};
      end else begin
         res.rem = trial[DEN_W-1:0];
         res.quo = {lane.quo[NUM_W-2:0], 1'b0};
      end
      return res;
   endfunction

endpackage

// ----- rtl/core/lpi_front.sv -----
// Differences, products and sign handling ahead of the divider.
module lpi_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic [lpi_pkg::IN_W-1:0]      in_data,
   output lpi_pkg::front_out_type        out
);

   localparam int CB = lpi_pkg::COORD_BITS;

   logic signed [CB-1:0] x1, y1, x2, y2, x3, y3, x4, y4;

   assign x1 = in_data[0*CB +: CB];
   assign y1 = in_data[1*CB +: CB];
   assign x2 = in_data[2*CB +: CB];
   assign y2 = in_data[3*CB +: CB];
   assign x3 = in_data[4*CB +: CB];
   assign y3 = in_data[5*CB +: CB];
   assign x4 = in_data[6*CB +: CB];
   assign y4 = in_data[7*CB +: CB];

   // Stage 1
   logic s1_valid_ff, s1_valid_in;
   logic signed [lpi_pkg::DIFF_W-1:0] dxa_ff, dya_ff, dxb_ff, dyb_ff;
   logic signed [lpi_pkg::DIFF_W-1:0] dxa_in, dya_in, dxb_in, dyb_in;
   logic signed [lpi_pkg::CROSS_W-1:0] pa1_ff, pa2_ff, pb1_ff, pb2_ff;
   logic signed [lpi_pkg::CROSS_W-1:0] pa1_in, pa2_in, pb1_in, pb2_in;

   assign s1_valid_in = in_valid;
   assign dxa_in = lpi_pkg::DIFF_W'(x1) - lpi_pkg::DIFF_W'(x2);
   assign dya_in = lpi_pkg::DIFF_W'(y1) - lpi_pkg::DIFF_W'(y2);
   assign dxb_in = lpi_pkg::DIFF_W'(x3) - lpi_pkg::DIFF_W'(x4);
   assign dyb_in = lpi_pkg::DIFF_W'(y3) - lpi_pkg::DIFF_W'(y4);
   assign pa1_in = lpi_pkg::CROSS_W'(x1) * lpi_pkg::CROSS_W'(y2);
   assign pa2_in = lpi_pkg::CROSS_W'(y1) * lpi_pkg::CROSS_W'(x2);
   assign pb1_in = lpi_pkg::CROSS_W'(x3) * lpi_pkg::CROSS_W'(y4);
   assign pb2_in = lpi_pkg::CROSS_W'(y3) * lpi_pkg::CROSS_W'(x4);

   // Stage 2
   logic s2_valid_ff;
   logic signed [lpi_pkg::DIFF_W-1:0]  dxa2_ff, dya2_ff, dxb2_ff, dyb2_ff;
   logic signed [lpi_pkg::PDEN_W-1:0]  pd1_ff, pd2_ff, pd1_in, pd2_in;
   logic signed [lpi_pkg::CROSS_W-1:0] ca_ff, cb_ff, ca_in, cb_in;

   assign pd1_in = lpi_pkg::PDEN_W'(dxa_ff) * lpi_pkg::PDEN_W'(dyb_ff);
   assign pd2_in = lpi_pkg::PDEN_W'(dya_ff) * lpi_pkg::PDEN_W'(dxb_ff);
   assign ca_in  = pa1_ff - pa2_ff;
   assign cb_in  = pb1_ff - pb2_ff;

   // Stage 3
   logic s3_valid_ff;
   logic signed [lpi_pkg::DEN_W-1:0]  den_ff, den_in;
   logic signed [lpi_pkg::PNUM_W-1:0] nx1_ff, nx2_ff, ny1_ff, ny2_ff;
   logic signed [lpi_pkg::PNUM_W-1:0] nx1_in, nx2_in, ny1_in, ny2_in;

   assign den_in = lpi_pkg::DEN_W'(pd1_ff) - lpi_pkg::DEN_W'(pd2_ff);
   assign nx1_in = lpi_pkg::PNUM_W'(ca_ff) * lpi_pkg::PNUM_W'(dxb2_ff);
   assign nx2_in = lpi_pkg::PNUM_W'(dxa2_ff) * lpi_pkg::PNUM_W'(cb_ff);
   assign ny1_in = lpi_pkg::PNUM_W'(ca_ff) * lpi_pkg::PNUM_W'(dyb2_ff);
   assign ny2_in = lpi_pkg::PNUM_W'(dya2_ff) * lpi_pkg::PNUM_W'(cb_ff);

   // Stage 4
   logic s4_valid_ff;
   logic signed [lpi_pkg::DEN_W-1:0] den4_ff;
   logic signed [lpi_pkg::NUM_W-1:0] numx_ff, numy_ff, numx_in, numy_in;

   assign numx_in = lpi_pkg::NUM_W'(nx1_ff) - lpi_pkg::NUM_W'(nx2_ff);
   assign numy_in = lpi_pkg::NUM_W'(ny1_ff) - lpi_pkg::NUM_W'(ny2_ff);

   // Stage 5: magnitudes and quotient signs.
   lpi_pkg::front_out_type out_ff, out_in;
   logic den_neg, nx_neg, ny_neg;

   always_comb begin
      den_neg = den4_ff[lpi_pkg::DEN_W-1];
      nx_neg  = numx_ff[lpi_pkg::NUM_W-1];
      ny_neg  = numy_ff[lpi_pkg::NUM_W-1];
      out_in.valid    = s4_valid_ff;
      out_in.neg_x    = nx_neg ^ den_neg;
      out_in.neg_y    = ny_neg ^ den_neg;
      out_in.den_zero = (den4_ff == '0);
      out_in.num_x    = nx_neg ? -numx_ff : numx_ff;
      out_in.num_y    = ny_neg ? -numy_ff : numy_ff;
      out_in.den      = den_neg ? -den4_ff : den4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         out_ff.valid  <= 1'b0;
      end else if (en) begin
         s1_valid_ff   <= s1_valid_in;
         s2_valid_ff   <= s1_valid_ff;
         s3_valid_ff   <= s2_valid_ff;
         s4_valid_ff   <= s3_valid_ff;
         out_ff.valid  <= out_in.valid;
      end
      if (en) begin
         dxa_ff  <= dxa_in;
         dya_ff  <= dya_in;
         dxb_ff  <= dxb_in;
         dyb_ff  <= dyb_in;
         pa1_ff  <= pa1_in;
         pa2_ff  <= pa2_in;
         pb1_ff  <= pb1_in;
         pb2_ff  <= pb2_in;
         dxa2_ff <= dxa_ff;
         dya2_ff <= dya_ff;
         dxb2_ff <= dxb_ff;
         dyb2_ff <= dyb_ff;
         pd1_ff  <= pd1_in;
         pd2_ff  <= pd2_in;
         ca_ff   <= ca_in;
         cb_ff   <= cb_in;
         den_ff  <= den_in;
         nx1_ff  <= nx1_in;
         nx2_ff  <= nx2_in;
         ny1_ff  <= ny1_in;
         ny2_ff  <= ny2_in;
         den4_ff <= den_ff;
         numx_ff <= numx_in;
         numy_ff <= numy_in;
         out_ff.neg_x    <= out_in.neg_x;
         out_ff.neg_y    <= out_in.neg_y;
         out_ff.den_zero <= out_in.den_zero;
         out_ff.num_x    <= out_in.num_x;
         out_ff.num_y    <= out_in.num_y;
         out_ff.den      <= out_in.den;
      end
   end

   assign out = out_ff;

endmodule

// ----- rtl/core/lpi_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, two lanes.
module lpi_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  lpi_pkg::front_out_type  in,
   output lpi_pkg::div_out_type    out
);

   localparam int NS = lpi_pkg::NUM_W;

   logic                         valid_ff [0:NS-1];
   logic                         negx_ff  [0:NS-1];
   logic                         negy_ff  [0:NS-1];
   logic                         dz_ff    [0:NS-1];
   logic [lpi_pkg::DEN_W-1:0]    d_ff     [0:NS-1];
   lpi_pkg::lane_type            lx_ff    [0:NS-1];
   lpi_pkg::lane_type            ly_ff    [0:NS-1];
   lpi_pkg::lane_type            lx_in    [0:NS-1];
   lpi_pkg::lane_type            ly_in    [0:NS-1];
   lpi_pkg::lane_type            lx_src, ly_src;

   always_comb begin
      lx_src.rem = '0;
      lx_src.quo = in.num_x;
      ly_src.rem = '0;
      ly_src.quo = in.num_y;
      lx_in[0] = lpi_pkg::div_step(lx_src, in.den);
      ly_in[0] = lpi_pkg::div_step(ly_src, in.den);
      for (int k = 1; k < NS; k++) begin
         lx_in[k] = lpi_pkg::div_step(lx_ff[k-1], d_ff[k-1]);
         ly_in[k] = lpi_pkg::div_step(ly_ff[k-1], d_ff[k-1]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) begin
            valid_ff[k] <= 1'b0;
         end
      end else if (en) begin
         valid_ff[0] <= in.valid;
         for (int k = 1; k < NS; k++) begin
            valid_ff[k] <= valid_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         negx_ff[0] <= in.neg_x;
         negy_ff[0] <= in.neg_y;
         dz_ff[0]   <= in.den_zero;
         d_ff[0]    <= in.den;
         for (int k = 1; k < NS; k++) begin
            negx_ff[k] <= negx_ff[k-1];
            negy_ff[k] <= negy_ff[k-1];
            dz_ff[k]   <= dz_ff[k-1];
            d_ff[k]    <= d_ff[k-1];
         end
         for (int k = 0; k < NS; k++) begin
            lx_ff[k] <= lx_in[k];
            ly_ff[k] <= ly_in[k];
         end
      end
   end

   assign out.valid    = valid_ff[NS-1];
   assign out.neg_x    = negx_ff[NS-1];
   assign out.neg_y    = negy_ff[NS-1];
   assign out.den_zero = dz_ff[NS-1];
   assign out.quo_x    = lx_ff[NS-1].quo;
   assign out.quo_y    = ly_ff[NS-1].quo;

endmodule

// ----- rtl/core/line_pair_intersection_top.sv -----
// Top level of the line pair intersection block.
// Input channel req_: one transaction carries two lines, each given by two
// points with signed coordinates. Result channel rsp_: one transaction per
// input transaction, in order, with the intersection point and a status of
// inside the image, parallel lines, or outside the image.
// Parallel lines give a zero point; an outside point is still reported.
// The csr_ port writes the image height and width used for the bounds check;
// write them only while no transaction is in flight.
// Throughput is one transaction per cycle unless rsp_tready stalls it. From
// input acceptance to rsp_tvalid a transaction passes the subtract and
// multiply stages, the divider with one bit of quotient per stage, and the
// output register. The whole pipeline advances together; when rsp_tvalid is
// high and rsp_tready is low every stage holds and req_tready is low.
// Reset empties the pipeline and sets the image to 480 rows by 640 columns.
module line_pair_intersection_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // a1_x, a1_y, a2_x, a2_y, b1_x, b1_y, b2_x, b2_y
   input  logic [lpi_pkg::IN_BYTES_W-1:0]     req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // cross_x, cross_y, status, zero fill
   output logic [lpi_pkg::OUT_BYTES_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic                               csr_index,
   input  logic [lpi_pkg::REG_W-1:0]          csr_wdata
);

   localparam int NW = lpi_pkg::NUM_W;
   localparam int OW = lpi_pkg::OUT_W;

   logic en;
   lpi_pkg::front_out_type front_out;
   lpi_pkg::div_out_type   div_out;

   logic [lpi_pkg::REG_W-1:0] rows_ff, cols_ff;

   logic                  rsp_valid_ff;
   logic [OW-1:0]         cx_ff, cy_ff, cx_in, cy_in;
   lpi_pkg::status_type   status_ff, status_in;
   logic signed [NW-1:0]  px, py;
   logic                  in_image;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= lpi_pkg::REG_W'(lpi_pkg::ROWS_RESET);
         cols_ff <= lpi_pkg::REG_W'(lpi_pkg::COLS_RESET);
      end else if (csr_we) begin
         unique case (lpi_pkg::reg_index_type'(csr_index))
            lpi_pkg::REG_IMAGE_ROWS: rows_ff <= csr_wdata;
            lpi_pkg::REG_IMAGE_COLS: cols_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   lpi_front u_front (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .in_data  (req_tdata[lpi_pkg::IN_W-1:0]),
      .out      (front_out)
   );

   lpi_divider u_divider (
      .clock (clock),
      .reset (reset),
      .en    (en),
      .in    (front_out),
      .out   (div_out)
   );

   always_comb begin
      px = div_out.neg_x ? -signed'(div_out.quo_x) : signed'(div_out.quo_x);
      py = div_out.neg_y ? -signed'(div_out.quo_y) : signed'(div_out.quo_y);
      in_image = !px[NW-1] && !py[NW-1] &&
                 (px < signed'(NW'(cols_ff))) && (py < signed'(NW'(rows_ff)));
      if (div_out.den_zero) begin
         cx_in     = '0;
         cy_in     = '0;
         status_in = lpi_pkg::STATUS_PARALLEL;
      end else begin
         cx_in     = px[OW-1:0];
         cy_in     = py[OW-1:0];
         status_in = in_image ? lpi_pkg::STATUS_INSIDE : lpi_pkg::STATUS_OUTSIDE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff     <= cx_in;
         cy_ff     <= cy_in;
         status_ff <= status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = lpi_pkg::OUT_BYTES_W'({status_ff, cy_ff, cx_ff});

endmodule

// ----- rtl/core/lpi_checker.sv -----
// Port checker for the line pair intersection block and its bind.
`include "line_pair_intersection_top_macros.svh"

module lpi_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [lpi_pkg::OUT_BYTES_W-1:0]  rsp_tdata
);

   localparam int OW = lpi_pkg::OUT_W;

   logic [1:0] status;

   assign status = rsp_tdata[2*OW +: 2];

   `LPI_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   `LPI_ASSERT_NEXT(a_hold_stall, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   `LPI_ASSERT_IMPL(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   `LPI_ASSERT_IMPL(a_status_code, clock, reset, rsp_tvalid,
      status != 2'd3)
   `LPI_ASSERT_IMPL(a_parallel_zero, clock, reset,
      rsp_tvalid && status == lpi_pkg::STATUS_PARALLEL,
      rsp_tdata[2*OW-1:0] == '0)

endmodule

bind line_pair_intersection_top lpi_checker u_lpi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ----- sim/testbench.sv -----
// Self-checking testbench for the line pair intersection block.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES = 300;
   localparam int CB = lpi_pkg::COORD_BITS;
   localparam int OW = lpi_pkg::OUT_W;
   localparam int RW = lpi_pkg::REG_W;

   typedef struct {
      logic signed [CB-1:0] a1_x, a1_y, a2_x, a2_y;
      logic signed [CB-1:0] b1_x, b1_y, b2_x, b2_y;
   } line_pair_type;

   typedef struct {
      logic [OW-1:0]       cross_x;
      logic [OW-1:0]       cross_y;
      lpi_pkg::status_type status;
   } crossing_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [lpi_pkg::IN_BYTES_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [lpi_pkg::OUT_BYTES_W-1:0] rsp_tdata;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [RW-1:0] csr_wdata = '0;

   logic [RW-1:0] model_rows = RW'(lpi_pkg::ROWS_RESET);
   logic [RW-1:0] model_cols = RW'(lpi_pkg::COLS_RESET);
   crossing_type pending_crossings[$];
   int mismatch_count = 0;
   int sent_count = 0;
   int checked_count = 0;
   int status_seen[3] = '{0, 0, 0};
   int cycle_count = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit long_hold = 1'b0;

   line_pair_intersection_top u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("line_pair_intersection_top test failed");
         $finish;
      end
   end

   function automatic crossing_type predict_crossing(line_pair_type p);
      longint dxa, dya, dxb, dyb, den, ca, cb, px, py;
      crossing_type r;
      dxa = longint'(p.a1_x) - longint'(p.a2_x);
      dya = longint'(p.a1_y) - longint'(p.a2_y);
      dxb = longint'(p.b1_x) - longint'(p.b2_x);
      dyb = longint'(p.b1_y) - longint'(p.b2_y);
      den = dxa * dyb - dya * dxb;
      if (den == 0) begin
         r.cross_x = '0;
         r.cross_y = '0;
         r.status = lpi_pkg::STATUS_PARALLEL;
         return r;
      end
      ca = longint'(p.a1_x) * longint'(p.a2_y) - longint'(p.a1_y) * longint'(p.a2_x);
      cb = longint'(p.b1_x) * longint'(p.b2_y) - longint'(p.b1_y) * longint'(p.b2_x);
      px = (ca * dxb - dxa * cb) / den;
      py = (ca * dyb - dya * cb) / den;
      r.cross_x = px[OW-1:0];
      r.cross_y = py[OW-1:0];
      if (px >= 0 && py >= 0 && px < longint'(model_cols) && py < longint'(model_rows))
         r.status = lpi_pkg::STATUS_INSIDE;
      else
         r.status = lpi_pkg::STATUS_OUTSIDE;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [OW-1:0] got, logic [OW-1:0] want);
      $display("mismatch %s at result %0d: got %0h expected %0h", what, checked_count, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      crossing_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_crossings.size() == 0) begin
            report_mismatch("unexpected transaction", rsp_tdata[OW-1:0], '0);
         end else begin
            want = pending_crossings.pop_front();
            if (rsp_tdata[OW-1:0] !== want.cross_x)
               report_mismatch("cross_x", rsp_tdata[OW-1:0], want.cross_x);
            if (rsp_tdata[2*OW-1:OW] !== want.cross_y)
               report_mismatch("cross_y", rsp_tdata[2*OW-1:OW], want.cross_y);
            if (rsp_tdata[2*OW+1:2*OW] !== want.status)
               report_mismatch("status", OW'(rsp_tdata[2*OW+1:2*OW]), OW'(want.status));
            status_seen[want.status]++;
         end
         checked_count++;
      end
   end

   always @(negedge clock) begin
      if (long_hold) begin
         rsp_tready <= 1'b0;
         repeat (HOLD_CYCLES - 1) @(negedge clock);
         long_hold = 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_pair(line_pair_type p);
      if ($urandom_range(99) < tx_idle_pct) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3)) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= {p.b2_y, p.b2_x, p.b1_y, p.b1_x, p.a2_y, p.a2_x, p.a1_y, p.a1_x};
      do @(posedge clock); while (!req_tready);
      pending_crossings.insert(pending_crossings.size(), predict_crossing(p));
      sent_count++;
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_crossings.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(lpi_pkg::reg_index_type idx, logic [RW-1:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == lpi_pkg::REG_IMAGE_ROWS) model_rows = value;
      else model_cols = value;
   endtask

   task automatic set_image(logic [RW-1:0] rows, logic [RW-1:0] cols);
      wait_idle();
      write_reg(lpi_pkg::REG_IMAGE_ROWS, rows);
      write_reg(lpi_pkg::REG_IMAGE_COLS, cols);
   endtask

   function automatic line_pair_type make_pair(int a1x, int a1y, int a2x, int a2y,
                                               int b1x, int b1y, int b2x, int b2y);
      line_pair_type p;
      p.a1_x = CB'(a1x); p.a1_y = CB'(a1y); p.a2_x = CB'(a2x); p.a2_y = CB'(a2y);
      p.b1_x = CB'(b1x); p.b1_y = CB'(b1y); p.b2_x = CB'(b2x); p.b2_y = CB'(b2y);
      return p;
   endfunction

   function automatic int rand_coord(int mode);
      case (mode)
         0: return int'($urandom_range(16383)) - 8192;
         1: return int'($urandom_range(900)) - 100;
         default: return int'($urandom_range(60)) - 30;
      endcase
   endfunction

   function automatic line_pair_type random_pair();
      int mode;
      int sx, sy;
      line_pair_type p;
      mode = $urandom_range(2);
      p = make_pair(rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode),
                    rand_coord(mode), rand_coord(mode), rand_coord(mode), rand_coord(mode));
      if ($urandom_range(9) == 0) begin
         // Line B becomes a shifted copy of line A, so the pair is parallel.
         sx = int'($urandom_range(40)) - 20;
         sy = int'($urandom_range(40)) - 20;
         p.b1_x = p.a1_x + CB'(sx); p.b1_y = p.a1_y + CB'(sy);
         p.b2_x = p.a2_x + CB'(sx); p.b2_y = p.a2_y + CB'(sy);
      end else if ($urandom_range(19) == 0) begin
         p.a2_x = p.a1_x;
         p.a2_y = p.a1_y;
      end
      return p;
   endfunction

   task automatic test_directed();
      send_pair(make_pair(0, 0, 10, 10, 0, 10, 10, 0));
      send_pair(make_pair(100, 200, 300, 200, 150, 0, 150, 400));
      send_pair(make_pair(639, 0, 639, 10, 0, 479, 10, 479));
      send_pair(make_pair(640, 0, 640, 10, 0, 480, 10, 480));
      send_pair(make_pair(-5, 0, -5, 10, 0, 3, 10, 3));
      send_pair(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
      send_pair(make_pair(0, 0, 3, 1, 0, -1, 3, 0));
      send_pair(make_pair(1, 1, 2, 2, 5, 5, 7, 7));
      send_pair(make_pair(0, 0, 1, 1, 0, 5, 1, 6));
      send_pair(make_pair(4, 4, 4, 4, 0, 0, 9, 3));
      send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 0));
      send_pair(make_pair(-8192, -8192, -8192, -8192, -8192, -8192, -8192, -8192));
      send_pair(make_pair(8191, 8191, 8191, 8191, 8191, 8191, 8191, 8191));
      send_pair(make_pair(-8192, -8192, 8191, 8191, -8192, 8191, 8191, -8192));
      send_pair(make_pair(-8192, 8191, -8191, -8192, 8191, 8191, 8190, -8192));
      send_pair(make_pair(-8192, 0, 8191, 1, 0, -8192, 1, 8191));
      send_pair(make_pair(8191, -8192, -8192, -8191, 8191, 8190, -8192, 8191));
      send_pair(make_pair(-8192, -8192, 8191, -8191, -8192, 8191, 8191, 8190));
      send_pair(make_pair(0, 0, 8191, 1, 0, 1, 8191, 0));
   endtask

   task automatic test_random(int count);
      repeat (count) send_pair(random_pair());
   endtask

   task automatic test_backpressure();
      long_hold = 1'b1;
      test_random(120);
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 18;
      rx_idle_pct = 73;
      test_directed();
      test_random(200);

      set_image(1, 1);
      test_random(40);
      set_image(0, 0);
      test_random(40);

      tx_idle_pct = 73;
      rx_idle_pct = 18;
      set_image(8192, 8192);
      test_random(200);
      set_image(16383, 100);
      test_random(40);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      set_image(480, 640);
      test_backpressure();
      test_random(100);

      wait_idle();
      $display("Checked %0d of %0d line pairs: %0d inside, %0d parallel, %0d outside.",
               checked_count, sent_count, status_seen[0], status_seen[1], status_seen[2]);
      $display("Image sizes from 0x0 to full register range, with stalls on both sides.");
      if (mismatch_count == 0 && pending_crossings.size() == 0) begin
         $display("line_pair_intersection_top test passed");
      end else begin
         $display("line_pair_intersection_top test failed");
      end
      $finish;
   end
endmodule
